[rtl/dre_pkg.sv]
// Types, step codes and control store of the DNS record wire encoder.
package dre_pkg;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic [1:0] CMD_CHAR  = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_HDR   = 2'd2;
  localparam logic [1:0] CMD_RDATA = 2'd3;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHAR  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_FLEN  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_FCHR  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RDATA = 4'd4;
  localparam logic [STEP_W-1:0] STEP_H0    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_H1    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_H2    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_H3    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_H4    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_H5    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_H6    = 4'd11;
  localparam logic [STEP_W-1:0] STEP_H7    = 4'd12;
  localparam logic [STEP_W-1:0] STEP_H8    = 4'd13;
  localparam logic [STEP_W-1:0] STEP_H9    = 4'd14;
  localparam logic [STEP_W-1:0] STEP_H10   = 4'd15;

  localparam logic [3:0] SRC_ZERO     = 4'd0;
  localparam logic [3:0] SRC_LEN      = 4'd1;
  localparam logic [3:0] SRC_STORE    = 4'd2;
  localparam logic [3:0] SRC_DATA     = 4'd3;
  localparam logic [3:0] SRC_TYPE_HI  = 4'd4;
  localparam logic [3:0] SRC_TYPE_LO  = 4'd5;
  localparam logic [3:0] SRC_CLASS_HI = 4'd6;
  localparam logic [3:0] SRC_CLASS_LO = 4'd7;
  localparam logic [3:0] SRC_TTL_3    = 4'd8;
  localparam logic [3:0] SRC_TTL_2    = 4'd9;
  localparam logic [3:0] SRC_TTL_1    = 4'd10;
  localparam logic [3:0] SRC_TTL_0    = 4'd11;
  localparam logic [3:0] SRC_RDLEN_HI = 4'd12;
  localparam logic [3:0] SRC_RDLEN_LO = 4'd13;

  localparam logic [1:0] LAST_NONE   = 2'd0;
  localparam logic [1:0] LAST_ALWAYS = 2'd1;
  localparam logic [1:0] LAST_END    = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_STORE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] SEQ_NEXT     = 3'd0;
  localparam logic [2:0] SEQ_IDLE     = 3'd1;
  localparam logic [2:0] SEQ_SKIP     = 3'd2;
  localparam logic [2:0] SEQ_LOOP     = 3'd3;
  localparam logic [2:0] SEQ_DISPATCH = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [15:0] rr_type;
    logic [15:0] rr_class;
    logic [31:0] time_to_live;
    logic [15:0] rdata_length;
  } in_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       last;
    logic       label_error;
  } out_t;

  typedef struct packed {
    logic       emit;
    logic [3:0] src;
    logic       err;
    logic [1:0] last;
    logic [1:0] act;
    logic [2:0] seq;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    cw = '{emit: 1'b0, src: SRC_ZERO, err: 1'b0, last: LAST_NONE, act: ACT_NONE,
           seq: SEQ_IDLE};
    case (step)
      STEP_IDLE:  cw.seq = SEQ_DISPATCH;
      STEP_CHAR:  cw.act = ACT_STORE;
      STEP_FLEN:  cw = '{1'b1, SRC_LEN, 1'b1, LAST_NONE, ACT_NONE, SEQ_SKIP};
      STEP_FCHR:  cw = '{1'b1, SRC_STORE, 1'b1, LAST_END, ACT_NONE, SEQ_LOOP};
      STEP_RDATA: cw = '{1'b1, SRC_DATA, 1'b0, LAST_ALWAYS, ACT_NONE, SEQ_IDLE};
      STEP_H0:    cw = '{1'b1, SRC_ZERO, 1'b0, LAST_NONE, ACT_CLEAR, SEQ_NEXT};
      STEP_H1:    cw = '{1'b1, SRC_TYPE_HI, 1'b0, LAST_NONE, ACT_NONE, SEQ_NEXT};
      STEP_H2:    cw = '{1'b1, SRC_TYPE_LO, 1'b0, LAST_NONE, ACT_NONE, SEQ_NEXT};
      STEP_H3:    cw = '{1'b1, SRC_CLASS_HI, 1'b0, LAST_NONE, ACT_NONE, SEQ_NEXT};
      STEP_H4:    cw = '{1'b1, SRC_CLASS_LO, 1'b0, LAST_NONE, ACT_NONE, SEQ_NEXT};
      STEP_H5:    cw = '{1'b1, SRC_TTL_3, 1'b0, LAST_NONE, ACT_NONE, SEQ_NEXT};
      STEP_H6:    cw = '{1'b1, SRC_TTL_2, 1'b0, LAST_NONE, ACT_NONE, SEQ_NEXT};
      STEP_H7:    cw = '{1'b1, SRC_TTL_1, 1'b0, LAST_NONE, ACT_NONE, SEQ_NEXT};
      STEP_H8:    cw = '{1'b1, SRC_TTL_0, 1'b0, LAST_NONE, ACT_NONE, SEQ_NEXT};
      STEP_H9:    cw = '{1'b1, SRC_RDLEN_HI, 1'b0, LAST_NONE, ACT_NONE, SEQ_NEXT};
      STEP_H10:   cw = '{1'b1, SRC_RDLEN_LO, 1'b0, LAST_ALWAYS, ACT_NONE, SEQ_IDLE};
      default:    cw.seq = SEQ_IDLE;
    endcase
    return cw;
  endfunction

  function automatic logic [STEP_W-1:0] entry(input logic [1:0] cmd, input logic [7:0] db);
    logic [STEP_W-1:0] s;
    case (cmd)
      CMD_CHAR:  s = (db == DOT_CHAR) ? STEP_FLEN : STEP_CHAR;
      CMD_END:   s = STEP_FLEN;
      CMD_HDR:   s = STEP_H0;
      CMD_RDATA: s = STEP_RDATA;
      default:   s = STEP_IDLE;
    endcase
    return s;
  endfunction

endpackage

[rtl/dre_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dre_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 63,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/dns_record_wire_encoder.sv]
// DNS resource record wire encoder: microcoded sequencer over a label buffer.
// Name character: dispatch, store. Dot or end of name: dispatch, the length byte, then the
// label characters from the label RAM, one byte per cycle unless the output stalls; an empty
// label emits no bytes. Header: dispatch, 11 bytes; rdata byte: dispatch, the byte.
// Output stalls hold the sequencer; the output register shows each result in the next cycle.
// Synchronous active-low reset empties the label and the output register; RAM is not cleared.
module dns_record_wire_encoder #(
  parameter int MAX_LABEL = 63
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dre_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dre_pkg::out_t out_data
);

  import dre_pkg::*;

  localparam int FILL_W = $clog2(MAX_LABEL + 1);
  localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
  localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_LABEL);

  logic [STEP_W-1:0] pc_r, pc_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic              dropped_r, dropped_nxt;
  in_t               item_r;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  ctrl_t             cw;
  logic              slot_free;
  logic              empty;
  logic              label_end;
  logic              emit_now;
  logic              advance;
  logic              wr_en;
  logic [7:0]        rd_data;
  logic [7:0]        src_byte;
  logic              last_bit;

  assign cw        = ucode(pc_r);
  assign slot_free = !out_valid_r || out_ready;
  assign empty     = (fill_r == '0);
  assign label_end = ((idx_r + FILL_W'(1)) == fill_r);
  assign emit_now  = cw.emit && !(cw.seq == SEQ_SKIP && empty);
  assign advance   = !emit_now || slot_free;
  assign in_ready  = (pc_r == STEP_IDLE);
  assign wr_en     = (cw.act == ACT_STORE) && (fill_r < MAX_FILL) && (item_r.data_byte != DOT_CHAR);

  dre_ram #(.WIDTH(8), .DEPTH(MAX_LABEL), .ADDR_W(ADDR_W)) u_label_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (item_r.data_byte),
    .rd_addr (idx_nxt[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    case (cw.src)
      SRC_ZERO:     src_byte = 8'h00;
      SRC_LEN:      src_byte = 8'(fill_r);
      SRC_STORE:    src_byte = rd_data;
      SRC_DATA:     src_byte = item_r.data_byte;
      SRC_TYPE_HI:  src_byte = item_r.rr_type[15:8];
      SRC_TYPE_LO:  src_byte = item_r.rr_type[7:0];
      SRC_CLASS_HI: src_byte = item_r.rr_class[15:8];
      SRC_CLASS_LO: src_byte = item_r.rr_class[7:0];
      SRC_TTL_3:    src_byte = item_r.time_to_live[31:24];
      SRC_TTL_2:    src_byte = item_r.time_to_live[23:16];
      SRC_TTL_1:    src_byte = item_r.time_to_live[15:8];
      SRC_TTL_0:    src_byte = item_r.time_to_live[7:0];
      SRC_RDLEN_HI: src_byte = item_r.rdata_length[15:8];
      SRC_RDLEN_LO: src_byte = item_r.rdata_length[7:0];
      default:      src_byte = 8'h00;
    endcase
    case (cw.last)
      LAST_ALWAYS: last_bit = 1'b1;
      LAST_END:    last_bit = label_end;
      default:     last_bit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt        = pc_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    if (emit_now && slot_free) begin
      out_valid_nxt       = 1'b1;
      out_nxt.wire_byte   = src_byte;
      out_nxt.last        = last_bit;
      out_nxt.label_error = cw.err && dropped_r;
    end

    if (advance) begin
      case (cw.act)
        ACT_STORE: begin
          if (item_r.data_byte != DOT_CHAR) begin
            if (fill_r < MAX_FILL) begin
              fill_nxt = fill_r + FILL_W'(1);
            end else begin
              dropped_nxt = 1'b1;
            end
          end
        end
        ACT_CLEAR: begin
          fill_nxt    = '0;
          dropped_nxt = 1'b0;
        end
        default: begin
        end
      endcase

      case (cw.seq)
        SEQ_NEXT: pc_nxt = pc_r + STEP_W'(1);
        SEQ_IDLE: pc_nxt = STEP_IDLE;
        SEQ_SKIP: begin
          idx_nxt = '0;
          pc_nxt  = empty ? STEP_IDLE : pc_r + STEP_W'(1);
        end
        SEQ_LOOP: begin
          if (label_end) begin
            fill_nxt    = '0;
            dropped_nxt = 1'b0;
            pc_nxt      = STEP_IDLE;
          end else begin
            idx_nxt = idx_r + FILL_W'(1);
          end
        end
        SEQ_DISPATCH: begin
          if (in_valid) begin
            pc_nxt = entry(in_data.command, in_data.data_byte);
          end
        end
        default: pc_nxt = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      fill_r      <= fill_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    out_r <= out_nxt;
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the DNS record wire encoder: byte predictor, stimulus, checks.
`timescale 1ns / 1ps

module tb_top;
  import dre_pkg::*;

  localparam int LABEL_MAX = 63;
  localparam int HOLD_CYCLES = 16;

  class rr_wire_board;
    logic [7:0]  label_chars [LABEL_MAX];
    int unsigned label_len;
    bit          label_cut;
    out_t        wire_bytes_due [$];
    int unsigned mismatches;

    function new();
      label_len = 0;
      label_cut = 1'b0;
      mismatches = 0;
    endfunction

    function void put_byte(input logic [7:0] b, input bit err);
      out_t r;
      r.wire_byte = b;
      r.last = 1'b0;
      r.label_error = err;
      wire_bytes_due.push_back(r);
    endfunction

    function void flush_label();
      if (label_len == 0) return;
      put_byte(8'(label_len), label_cut);
      for (int unsigned i = 0; i < label_len; i++) put_byte(label_chars[i], label_cut);
      label_len = 0;
      label_cut = 1'b0;
    endfunction

    function void encode_item(input in_t it);
      int unsigned n_due;
      out_t        tail;
      n_due = wire_bytes_due.size();
      case (it.command)
        CMD_CHAR: begin
          if (it.data_byte == DOT_CHAR) begin
            flush_label();
          end else if (label_len < LABEL_MAX) begin
            label_chars[label_len] = it.data_byte;
            label_len++;
          end else begin
            label_cut = 1'b1;
          end
        end
        CMD_END: begin
          flush_label();
        end
        CMD_HDR: begin
          label_len = 0;
          label_cut = 1'b0;
          put_byte(8'h00, 1'b0);
          put_byte(it.rr_type[15:8], 1'b0);
          put_byte(it.rr_type[7:0], 1'b0);
          put_byte(it.rr_class[15:8], 1'b0);
          put_byte(it.rr_class[7:0], 1'b0);
          put_byte(it.time_to_live[31:24], 1'b0);
          put_byte(it.time_to_live[23:16], 1'b0);
          put_byte(it.time_to_live[15:8], 1'b0);
          put_byte(it.time_to_live[7:0], 1'b0);
          put_byte(it.rdata_length[15:8], 1'b0);
          put_byte(it.rdata_length[7:0], 1'b0);
        end
        default: begin
          put_byte(it.data_byte, 1'b0);
        end
      endcase
      if (wire_bytes_due.size() > n_due) begin
        tail = wire_bytes_due.pop_back();
        tail.last = 1'b1;
        wire_bytes_due.push_back(tail);
      end
    endfunction

    function void note_fault(input string msg);
      if (mismatches < 10) $display("%0t: %s", $time, msg);
      mismatches++;
    endfunction

    function void match_wire_byte(input out_t got);
      out_t want;
      if (wire_bytes_due.size() == 0) begin
        note_fault($sformatf("unexpected wire byte %02h last %0b err %0b",
                             got.wire_byte, got.last, got.label_error));
        return;
      end
      want = wire_bytes_due.pop_front();
      if (got.wire_byte !== want.wire_byte || got.last !== want.last ||
          got.label_error !== want.label_error) begin
        note_fault($sformatf("expected byte %02h last %0b err %0b, got byte %02h last %0b err %0b",
                             want.wire_byte, want.last, want.label_error,
                             got.wire_byte, got.last, got.label_error));
      end
    endfunction

    function void check_drained();
      if (wire_bytes_due.size() != 0)
        note_fault($sformatf("%0d wire bytes never arrived", wire_bytes_due.size()));
    endfunction

    function int unsigned pending();
      return wire_bytes_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int unsigned items_sent = 0;

  rr_wire_board board = new();

  dns_record_wire_encoder #(
    .MAX_LABEL(LABEL_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.match_wire_byte(out_data);
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic in_t mk_item(input logic [1:0] cmd, input logic [7:0] db);
    in_t it;
    it.command = cmd;
    it.data_byte = db;
    it.rr_type = 16'($urandom);
    it.rr_class = 16'($urandom);
    it.time_to_live = $urandom;
    it.rdata_length = 16'($urandom);
    return it;
  endfunction

  function automatic in_t mk_hdr(input logic [15:0] rtype, input logic [15:0] rclass,
                                 input logic [31:0] ttl, input logic [15:0] rdlen);
    in_t it;
    it = mk_item(CMD_HDR, 8'($urandom));
    it.rr_type = rtype;
    it.rr_class = rclass;
    it.time_to_live = ttl;
    it.rdata_length = rdlen;
    return it;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] b;
    do b = 8'($urandom); while (b == DOT_CHAR);
    return b;
  endfunction

  task automatic send_item(input in_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    board.encode_item(it);
    items_sent++;
  endtask

  task automatic send_record(input bit force_long);
    int unsigned n_labels;
    int unsigned len;
    n_labels = $urandom_range(4);
    if (force_long && n_labels == 0) n_labels = 1;
    for (int unsigned l = 0; l < n_labels; l++) begin
      if (force_long && l == 0) len = LABEL_MAX + 3;
      else if ($urandom_range(99) < 5) len = $urandom_range(LABEL_MAX + 6, LABEL_MAX - 4);
      else len = $urandom_range(12);
      repeat (len) send_item(mk_item(CMD_CHAR, name_char()));
      if (l + 1 < n_labels || $urandom_range(9) == 0)
        send_item(mk_item(CMD_CHAR, DOT_CHAR));
    end
    if ($urandom_range(99) < 85) send_item(mk_item(CMD_END, 8'($urandom)));
    send_item(mk_item(CMD_HDR, 8'($urandom)));
    repeat ($urandom_range(8)) send_item(mk_item(CMD_RDATA, 8'($urandom)));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 1))
      send_item(mk_item(2'($urandom), ($urandom_range(3) == 0) ? DOT_CHAR : 8'($urandom)));
  endtask

  task automatic drain_and_hold();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned base;
    bit          first_record;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 31;
    out_idle_pct = 56;

    send_item(mk_item(CMD_RDATA, 8'h00));
    send_item(mk_item(CMD_RDATA, 8'hFF));
    send_item(mk_item(CMD_RDATA, DOT_CHAR));
    send_item(mk_item(CMD_CHAR, DOT_CHAR));
    send_item(mk_item(CMD_END, 8'hFF));
    send_item(mk_item(CMD_CHAR, 8'h00));
    send_item(mk_item(CMD_CHAR, 8'hFF));
    send_item(mk_item(CMD_CHAR, 8'h2D));
    send_item(mk_item(CMD_CHAR, DOT_CHAR));
    send_item(mk_item(CMD_CHAR, 8'h41));
    send_item(mk_item(CMD_CHAR, 8'h7A));
    send_item(mk_item(CMD_END, 8'h00));
    send_item(mk_hdr(16'h0000, 16'h0000, 32'h0000_0000, 16'h0000));
    send_item(mk_hdr(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(mk_hdr(16'h1234, 16'h00FF, 32'h89AB_CDEF, 16'hFF00));
    send_item(mk_item(CMD_CHAR, 8'h78));
    send_item(mk_item(CMD_CHAR, 8'h79));
    send_item(mk_hdr(16'h0001, 16'h0001, 32'h0000_0E10, 16'h0004));
    send_item(mk_item(CMD_END, 8'h55));

    base = items_sent;
    first_record = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct = 31;
          out_idle_pct = 56;
        end
        1: begin
          in_idle_pct = 56;
          out_idle_pct = 31;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      while (items_sent < base + 170 * (ph + 1) - 10 * (ph / 2)) begin
        if (!first_record && $urandom_range(99) < 15) send_noise();
        else send_record(first_record);
        first_record = 1'b0;
      end
      drain_and_hold();
    end

    board.check_drained();
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[dns_record_wire_encoder.f]
rtl/dre_pkg.sv
rtl/dre_ram.sv
rtl/dns_record_wire_encoder.sv
tb/tb_top.sv
